### rtl/core/assert_macros.svh
// Assertion macros for the airtime budget tracker RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/cabt_pkg.sv
// Types and constants of the channel airtime budget tracker.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package cabt_pkg;

   localparam int CHAN_W  = 5;
   localparam int TOTAL_W = 6;
   localparam int TIME_W  = 32;
   localparam int MASK_W  = 32;

   // A window is one hour of microseconds; a channel may use one percent of it.
   localparam int SECONDS_PER_WINDOW = 3600;
   localparam int US_PER_SECOND      = 1000000;
   localparam int DUTY_DIVISOR       = 100;

   localparam logic [TOTAL_W-1:0] CHAN_COUNT_RESET = 6'd32;
   localparam logic [TIME_W-1:0]  BUDGET_RESET     =
      32'(SECONDS_PER_WINDOW * (US_PER_SECOND / DUTY_DIVISOR));

   typedef enum logic [0:0] {
      CABT_OP_REPORT  = 1'b0,
      CABT_OP_RESTART = 1'b1
   } cabt_op_type;

   typedef enum logic [0:0] {
      CABT_CSR_CHAN_COUNT = 1'b0,
      CABT_CSR_BUDGET_US  = 1'b1
   } cabt_csr_type;

   typedef struct packed {
      cabt_op_type        op;
      logic [CHAN_W-1:0]  channel;
      logic [TIME_W-1:0]  tx_us;
   } cabt_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] lifetime_used_us;
      logic [TIME_W-1:0] window_used_us;
      logic [MASK_W-1:0] available_mask;
   } cabt_rsp_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] chan_count;
      logic [TIME_W-1:0]  budget_us;
   } cabt_cfg_type;

endpackage

### rtl/core/cabt_req_stage.sv
// Input register of the airtime budget tracker: holds one request for the engine.
// Depends on cabt_pkg.
`timescale 1ns / 1ps

module cabt_req_stage
   import cabt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  cabt_req_type in_req,
   input  logic         downstream_ready,
   output logic         hold_valid,
   output cabt_req_type hold_req
);

   logic         valid_ff, valid_in;
   cabt_req_type req_ff;
   logic         load;

   // The slot frees up in the same cycle the engine consumes its request.
   assign in_ready = !valid_ff || downstream_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (downstream_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff <= in_req;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_req   = req_ff;

endmodule

### rtl/core/cabt_engine.sv
// Per-channel airtime counters, availability mask and their update logic.
// Depends on cabt_pkg.
`timescale 1ns / 1ps

module cabt_engine
   import cabt_pkg::*;
#(
   parameter int NUM_CHANNELS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  cabt_req_type req,
   input  cabt_cfg_type cfg,
   output cabt_rsp_type rsp
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [TOTAL_W-1:0] CHAN_LIMIT = TOTAL_W'(NUM_CHANNELS);
   localparam logic [MASK_W-1:0]  CHAN_MASK  =
      MASK_W'((64'd1 << NUM_CHANNELS) - 64'd1);

   logic [TIME_W-1:0]       win_ff  [NUM_CHANNELS];
   logic [TIME_W-1:0]       life_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] win_valid_ff, win_valid_in;
   logic [NUM_CHANNELS-1:0] life_valid_ff, life_valid_in;
   logic [MASK_W-1:0]       mask_ff, mask_in;

   logic              chan_ok;
   logic [IDX_W-1:0]  idx;
   logic [TIME_W-1:0] win_rd, life_rd;
   logic [TIME_W:0]   win_sum, life_sum;
   logic [TIME_W+1:0] probe;
   logic [TIME_W-1:0] win_in, life_in;
   logic              over_budget;
   logic [MASK_W-1:0] restart_mask;
   logic              do_report, do_restart;

   assign chan_ok = {1'b0, req.channel} < CHAN_LIMIT;
   assign idx     = chan_ok ? req.channel[IDX_W-1:0] : '0;

   // An entry that has not been written since its last clear reads as zero.
   assign win_rd  = win_valid_ff[idx]  ? win_ff[idx]  : '0;
   assign life_rd = life_valid_ff[idx] ? life_ff[idx] : '0;

   assign win_sum  = {1'b0, win_rd}  + {1'b0, req.tx_us};
   assign life_sum = {1'b0, life_rd} + {1'b0, req.tx_us};
   assign win_in   = win_sum[TIME_W]  ? '1 : win_sum[TIME_W-1:0];
   assign life_in  = life_sum[TIME_W] ? '1 : life_sum[TIME_W-1:0];

   // Room for one more transmission of the same length. When the window
   // count saturates, the saturated value plus a nonzero length always
   // exceeds any budget, so only the unsaturated sum needs the probe.
   assign probe = {2'b00, win_rd} + {2'b00, req.tx_us} + {2'b00, req.tx_us};
   assign over_budget = (req.tx_us != '0) &&
                        (win_sum[TIME_W] || (probe > {2'b00, cfg.budget_us}));

   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         restart_mask[i] = CHAN_MASK[i] && (TOTAL_W'(i) < cfg.chan_count);
      end
   end

   assign do_restart = fire && (req.op == CABT_OP_RESTART);
   assign do_report  = fire && (req.op == CABT_OP_REPORT) && chan_ok;

   always_comb begin
      win_valid_in  = win_valid_ff;
      life_valid_in = life_valid_ff;
      mask_in       = mask_ff;
      if (do_restart) begin
         win_valid_in = '0;
         mask_in      = restart_mask;
      end else if (do_report) begin
         win_valid_in[idx]  = 1'b1;
         life_valid_in[idx] = 1'b1;
         if (over_budget) begin
            mask_in = mask_ff & ~(MASK_W'(1) << req.channel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff  <= '0;
         life_valid_ff <= '0;
         mask_ff       <= CHAN_MASK;
      end else begin
         win_valid_ff  <= win_valid_in;
         life_valid_ff <= life_valid_in;
         mask_ff       <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_report) begin
         win_ff[idx]  <= win_in;
         life_ff[idx] <= life_in;
      end
   end

   // Result as it will stand after this request's update.
   always_comb begin
      rsp.available_mask   = mask_in;
      rsp.window_used_us   = '0;
      rsp.lifetime_used_us = '0;
      if (chan_ok) begin
         if (req.op == CABT_OP_RESTART) begin
            rsp.lifetime_used_us = life_rd;
         end else begin
            rsp.window_used_us   = win_in;
            rsp.lifetime_used_us = life_in;
         end
      end
   end

endmodule

### rtl/core/cabt_rsp_stage.sv
// Result register of the airtime budget tracker, parting the engine from the output.
// Depends on cabt_pkg.
`timescale 1ns / 1ps

module cabt_rsp_stage
   import cabt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  cabt_rsp_type in_rsp,
   output logic         can_load,
   output logic         out_valid,
   input  logic         out_ready,
   output cabt_rsp_type out_rsp
);

   logic         valid_ff, valid_in;
   cabt_rsp_type rsp_ff;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= in_rsp;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

### rtl/core/channel_airtime_budget_tracker.sv
// Top level of the per-channel airtime budget tracker.
// Depends on cabt_pkg, cabt_req_stage, cabt_engine, cabt_rsp_stage, assert_macros.svh.
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  tuser: op; tdata: channel, tx_us
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: mask, window, lifetime
//   csr_      in         csr_wen                csr_index, csr_wdata
//
// One request is taken in every cycle while rsp_tready keeps up; it waits in the input
// register, and its result is loaded into the result register. The rate is set
// by the single engine pass that reads, updates and writes the addressed channel's
// counters between the input and result registers.
// Reset is synchronous; counters clear at once through per-entry valid bits, so
// there is no clearing pass. When rsp_tready is low the result register holds,
// the input register takes one more request, and then req_tready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module channel_airtime_budget_tracker
   import cabt_pkg::*;
#(
   parameter int NUM_CHANNELS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [4:0] channel, [36:5] tx_us, [39:37] zero
   input  logic [0:0]  req_tuser,   // [0] op
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] available_mask, [63:32] window_used_us,
                                    // [95:64] lifetime_used_us
   // Configuration write port.
   input  logic        csr_wen,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [MASK_W-1:0] CHAN_MASK =
      MASK_W'((64'd1 << NUM_CHANNELS) - 64'd1);

   cabt_cfg_type cfg_ff, cfg_in;
   cabt_req_type in_req, hold_req;
   cabt_rsp_type eng_rsp, out_rsp;
   logic         hold_valid;
   logic         can_load;
   logic         fire;

   // Config regs; user writes must arrive only while the block is idle; not enforced.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (cabt_csr_type'(csr_index))
            CABT_CSR_CHAN_COUNT: cfg_in.chan_count = csr_wdata[TOTAL_W-1:0];
            CABT_CSR_BUDGET_US:  cfg_in.budget_us  = csr_wdata[TIME_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chan_count <= CHAN_COUNT_RESET;
         cfg_ff.budget_us  <= BUDGET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the request fields from the stream words.
   assign in_req.op      = cabt_op_type'(req_tuser[0]);
   assign in_req.channel = req_tdata[CHAN_W-1:0];
   assign in_req.tx_us   = req_tdata[CHAN_W+TIME_W-1:CHAN_W];

   cabt_req_stage u_req_stage (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .in_req           (in_req),
      .downstream_ready (can_load),
      .hold_valid       (hold_valid),
      .hold_req         (hold_req)
   );

   // The engine commits its state update in the same cycle the result is captured.
   assign fire = hold_valid && can_load;

   cabt_engine #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (hold_req),
      .cfg   (cfg_ff),
      .rsp   (eng_rsp)
   );

   cabt_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .in_rsp    (eng_rsp),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (out_rsp)
   );

   assign rsp_tdata = {out_rsp.lifetime_used_us, out_rsp.window_used_us,
                       out_rsp.available_mask};

   // A window count can never run ahead of the lifetime count of the same channel.
   `ASSERT_IMPLIES(a_window_le_lifetime, clock, reset, rsp_tvalid,
      out_rsp.window_used_us <= out_rsp.lifetime_used_us)
   // Channels beyond NUM_CHANNELS are never reported as available.
   `ASSERT_IMPLIES(a_mask_in_range, clock, reset, rsp_tvalid,
      (out_rsp.available_mask & ~CHAN_MASK) == '0)
   // A restart's result shows an empty window.
   `ASSERT_NEXT(a_restart_clears_window, clock, reset,
      fire && (hold_req.op == CABT_OP_RESTART),
      rsp_tvalid && (out_rsp.window_used_us == '0))

endmodule

### dv/tb_channel_airtime_budget_tracker.sv
// Self-checking testbench for the per-channel airtime budget tracker.
// Depends on cabt_pkg and channel_airtime_budget_tracker; the expected results
// come from an in-bench predictor that tracks every channel's counters and the mask.
`timescale 1ns / 1ps

module tb_channel_airtime_budget_tracker;
   import cabt_pkg::*;

   localparam int NUM_CHANNELS    = 32;
   localparam int CLK_PERIOD      = 10;
   // Allowance for the input and result registers between a request and its result.
   localparam int PIPE_LATENCY    = 2;
   // Length of the one long receiver hold-off, in cycles.
   localparam int RSP_HOLD_CYCLES = 300;
   // Cycles without any accepted request, result or register write before
   // the run is declared hung. The slowest correct stretch is the hold-off
   // above, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_REQUESTS  = 250;
   localparam int MAX_REPORTED    = 10;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [39:0]   req_tdata;    // [4:0] channel, [36:5] tx_us, [39:37] zero
   logic [0:0]    req_tuser;    // [0] op
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [95:0]   rsp_tdata;    // [31:0] available_mask, [63:32] window_used_us,
                                // [95:64] lifetime_used_us
   logic          csr_wen;
   logic [0:0]    csr_index;
   logic [31:0]   csr_wdata;

   channel_airtime_budget_tracker #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predicted state of the block: per-channel window and lifetime airtime,
   // the mask of channels that still have budget, and the two registers.
   logic [TIME_W-1:0]  chan_window_us   [NUM_CHANNELS];
   logic [TIME_W-1:0]  chan_lifetime_us [NUM_CHANNELS];
   logic [MASK_W-1:0]  allowed_chans;
   logic [TOTAL_W-1:0] cfg_chan_count;
   logic [TIME_W-1:0]  cfg_budget_us;

   // Channel status that each accepted request is expected to return, oldest first.
   cabt_rsp_type channel_status_q [$];

   int mismatches  = 0;
   int idle_cycles = 0;

   // Traffic shaping shared between the test tasks and the two drivers.
   bit req_burst    = 1'b0;   // sender offers back to back, no gaps
   bit rsp_burst    = 1'b0;   // receiver stays ready, no gaps
   bit rsp_hold_req = 1'b0;   // ask the receiver for one long hold-off

   initial begin : clock_gen
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mask that a window restart loads: the low channel-count bits, where any
   // count at or above the number of channels means every channel.
   function automatic logic [MASK_W-1:0] restart_mask(logic [TOTAL_W-1:0] total);
      if (total >= NUM_CHANNELS) return '1;
      return (MASK_W'(1) << total) - 1'b1;
   endfunction

   function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   endfunction

   // Applies one request to the predicted state and returns the status the
   // block must report for it. A report adds its airtime to both counters of
   // the channel, saturating; the channel loses budget when the updated window
   // time plus one more transmission of the same length would exceed the
   // budget. That compare runs at full width so it never wraps. A zero-length
   // report leaves everything as it was.
   function automatic cabt_rsp_type account_airtime(cabt_op_type op,
                                                    logic [CHAN_W-1:0] ch,
                                                    logic [TIME_W-1:0] tx);
      cabt_rsp_type status;
      if (op == CABT_OP_RESTART) begin
         foreach (chan_window_us[i]) chan_window_us[i] = '0;
         allowed_chans = restart_mask(cfg_chan_count);
      end else begin
         chan_window_us[ch]   = sat_sum(chan_window_us[ch], tx);
         chan_lifetime_us[ch] = sat_sum(chan_lifetime_us[ch], tx);
         if (tx != '0 &&
             ({2'b00, chan_window_us[ch]} + {2'b00, tx}) > {2'b00, cfg_budget_us})
            allowed_chans[ch] = 1'b0;
      end
      status.available_mask   = allowed_chans;
      status.window_used_us   = chan_window_us[ch];
      status.lifetime_used_us = chan_lifetime_us[ch];
      return status;
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTED)
         $display("%0t ns: %s mismatch: expected %h, got %h", $realtime, what, want, got);
   endfunction

   // Register writes and accepted requests update the predictor at the same
   // edge at which the block takes them.
   always @(posedge clock) begin : request_monitor
      if (reset) begin
         foreach (chan_window_us[i]) begin
            chan_window_us[i]   = '0;
            chan_lifetime_us[i] = '0;
         end
         cfg_chan_count = CHAN_COUNT_RESET;
         cfg_budget_us  = BUDGET_RESET;
         allowed_chans  = restart_mask(CHAN_COUNT_RESET);
         channel_status_q.delete();
      end else begin
         if (csr_wen) begin
            case (cabt_csr_type'(csr_index))
               CABT_CSR_CHAN_COUNT: cfg_chan_count = csr_wdata[TOTAL_W-1:0];
               CABT_CSR_BUDGET_US:  cfg_budget_us  = csr_wdata;
            endcase
         end
         if (req_tvalid && req_tready)
            channel_status_q.push_back(account_airtime(cabt_op_type'(req_tuser[0]),
                                                       req_tdata[4:0], req_tdata[36:5]));
      end
   end

   // Every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin : status_checker
      cabt_rsp_type seen;
      cabt_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = cabt_rsp_type'(rsp_tdata);
         if (channel_status_q.size() == 0) begin
            note_mismatch("unexpected result, mask", '0, seen.available_mask);
         end else begin
            want = channel_status_q.pop_front();
            if (seen.available_mask !== want.available_mask)
               note_mismatch("available_mask", want.available_mask, seen.available_mask);
            if (seen.window_used_us !== want.window_used_us)
               note_mismatch("window_used_us", want.window_used_us, seen.window_used_us);
            if (seen.lifetime_used_us !== want.lifetime_used_us)
               note_mismatch("lifetime_used_us", want.lifetime_used_us,
                             seen.lifetime_used_us);
         end
      end
   end

   // Any handshake or register write counts as progress.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[channel_airtime_budget_tracker] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result-side ready. Random gaps with stretches of none, plus one long
   // hold-off on request that this process times on its own.
   initial begin : result_ready_driver
      int gap_left;
      int hold_left;
      rsp_tready = 1'b0;
      gap_left   = 0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 127) == 0) rsp_burst = ($urandom_range(0, 2) == 0);
         if (rsp_hold_req) begin
            rsp_tready = 1'b0;
            for (hold_left = RSP_HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clock);
            rsp_hold_req = 1'b0;
         end else if (gap_left > 0) begin
            rsp_tready = 1'b0;
            gap_left--;
         end else begin
            rsp_tready = 1'b1;
            gap_left   = rsp_burst ? 0 : idle_gap();
         end
      end
   end

   // Offers one request and returns once it is accepted. Valid stays high when
   // no gap follows, so the next call simply replaces the payload.
   task automatic send_request(cabt_op_type op, logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] tx);
      int gap;
      gap = req_burst ? 0 : idle_gap();
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {3'b000, tx, ch};
      do @(posedge clock); while (!req_tready);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata  = 40'({$urandom, $urandom});
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stops offering and lets the block run dry before the next phase.
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (channel_status_q.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_csr(cabt_csr_type idx, logic [31:0] value);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wen   = 1'b0;
      csr_wdata = $urandom;
   endtask

   // Reports at the reset settings: zero-length reports, saturation of both
   // counters, reports on a channel whose bit is already cleared, and window
   // restarts addressing channels with history.
   task automatic test_report_extremes();
      send_request(CABT_OP_REPORT,  5'd0,  32'd0);
      send_request(CABT_OP_REPORT,  5'd0,  32'd1);
      send_request(CABT_OP_REPORT,  5'd31, BUDGET_RESET);
      send_request(CABT_OP_REPORT,  5'd5,  32'hFFFF_FFFF);
      send_request(CABT_OP_REPORT,  5'd5,  32'hFFFF_FFFF);
      send_request(CABT_OP_REPORT,  5'd5,  32'd0);
      send_request(CABT_OP_REPORT,  5'd31, 32'd5);
      send_request(CABT_OP_REPORT,  5'd16, 32'h8000_0000);
      send_request(CABT_OP_REPORT,  5'd10, BUDGET_RESET / 2);
      send_request(CABT_OP_REPORT,  5'd10, 32'd1);
      send_request(CABT_OP_RESTART, 5'd5,  $urandom);
      send_request(CABT_OP_RESTART, 5'd31, 32'hFFFF_FFFF);
      send_request(CABT_OP_REPORT,  5'd5,  32'd7);
      settle();
   endtask

   // Register extremes: a zero budget, the largest budget where only the
   // full-width compare tells apart fit from overflow, and channel counts of
   // zero, one, just below and far above the number of channels.
   task automatic test_register_extremes();
      write_csr(CABT_CSR_BUDGET_US, 32'd0);
      write_csr(CABT_CSR_CHAN_COUNT, 32'd0);
      send_request(CABT_OP_RESTART, 5'd3, 32'd0);
      send_request(CABT_OP_REPORT,  5'd3, 32'd1);
      send_request(CABT_OP_REPORT,  5'd3, 32'd0);
      settle();
      write_csr(CABT_CSR_BUDGET_US, 32'hFFFF_FFFF);
      write_csr(CABT_CSR_CHAN_COUNT, 32'd63);
      send_request(CABT_OP_RESTART, 5'd2, 32'd0);
      send_request(CABT_OP_REPORT,  5'd2, 32'h7FFF_FFFF);
      send_request(CABT_OP_REPORT,  5'd2, 32'h7FFF_FFFF);
      send_request(CABT_OP_REPORT,  5'd2, 32'd1);
      send_request(CABT_OP_REPORT,  5'd2, 32'd5);
      settle();
      write_csr(CABT_CSR_CHAN_COUNT, 32'd1);
      send_request(CABT_OP_RESTART, 5'd0, 32'd0);
      settle();
      write_csr(CABT_CSR_CHAN_COUNT, 32'd31);
      send_request(CABT_OP_RESTART, 5'd30, 32'd0);
      settle();
      write_csr(CABT_CSR_CHAN_COUNT, 32'(CHAN_COUNT_RESET));
      write_csr(CABT_CSR_BUDGET_US, BUDGET_RESET);
      send_request(CABT_OP_RESTART, 5'd0, 32'd0);
      settle();
   endtask

   // The receiver stops for a long stretch while requests keep coming back to
   // back, so the block fills and must drop req_tready without losing anything.
   task automatic test_result_backpressure();
      req_burst    = 1'b1;
      rsp_hold_req = 1'b1;
      for (int n = 0; n < 24; n++)
         send_request(CABT_OP_REPORT, CHAN_W'(n), $urandom_range(0, 5000));
      req_burst = 1'b0;
      settle();
   endtask

   // Random traffic in phases, each under its own register setting. Each
   // phase opens with a restart so the mask follows the new channel count.
   // Half the reports go to a few hot channels so windows fill up and bits
   // clear; airtimes are mostly scaled to the budget, with zero, full-range
   // and all-ones values mixed in.
   task automatic test_random_traffic();
      logic [TOTAL_W-1:0] total;
      logic [TIME_W-1:0]  budget;
      logic [TIME_W-1:0]  tx;
      logic [CHAN_W-1:0]  ch;
      cabt_op_type        op;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin total = CHAN_COUNT_RESET;    budget = BUDGET_RESET;   end
            1: begin total = 6'd63;               budget = 32'hFFFF_FFFF;  end
            2: begin total = 6'd1;                budget = 32'd0;          end
            3: begin total = 6'd0;                budget = $urandom_range(1000, 100000); end
            default: begin
               total  = TOTAL_W'($urandom_range(0, 63));
               budget = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 1 << 20) : $urandom;
            end
         endcase
         write_csr(CABT_CSR_CHAN_COUNT, 32'(total));
         write_csr(CABT_CSR_BUDGET_US, budget);
         send_request(CABT_OP_RESTART, CHAN_W'($urandom), $urandom);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % 64 == 0) req_burst = ($urandom_range(0, 3) == 0);
            op = ($urandom_range(0, 39) == 0) ? CABT_OP_RESTART : CABT_OP_REPORT;
            ch = ($urandom_range(0, 1) == 0) ? CHAN_W'($urandom_range(0, 3))
                                              : CHAN_W'($urandom);
            case ($urandom_range(0, 9))
               0:       tx = '0;
               1:       tx = $urandom;
               2:       tx = '1;
               3, 4:    tx = $urandom_range(budget / 2, budget);
               default: tx = $urandom_range(0, budget / 16 + 1);
            endcase
            send_request(op, ch, tx);
         end
         req_burst = 1'b0;
         settle();
      end
   endtask

   initial begin : test_sequence
      int waited;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_report_extremes();
      test_register_extremes();
      test_result_backpressure();
      test_random_traffic();

      // Every test already drains, so this only bounds the final wait.
      waited = 0;
      while (channel_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (channel_status_q.size() != 0)
         note_mismatch("results left outstanding", '0, channel_status_q.size());

      if (mismatches == 0) begin
         $display("[channel_airtime_budget_tracker] OK");
      end else begin
         $display("[channel_airtime_budget_tracker] ERROR");
      end
      $finish;
   end

endmodule
